@@ sv/tld_pkg.sv @@
// Shared types and constants for the thick-line decomposer.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package tld_pkg;

  localparam int LINE_W = 14;
  localparam int CFG_W  = 13;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd320;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd240;

  typedef enum logic {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } tld_reg_t;

  typedef enum logic [1:0] {
    MODE_CENTER = 2'd0,
    MODE_CW     = 2'd1,
    MODE_CCW    = 2'd2
  } tld_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLIP,
    ST_DELTA,
    ST_SETUP,
    ST_ADJ,
    ST_EMIT
  } tld_state_t;

  typedef struct packed {
    logic major_x;
    logic neg_p;
    logic neg_s;
    logic retreat;
  } tld_step_ctl_t;

  function automatic logic signed [17:0] clip(input logic signed [15:0] v,
                                               input logic signed [17:0] lim);
    logic signed [17:0] r;
    r = 18'(v);
    if (r >= lim) begin
      r = lim - 18'sd1;
    end
    if (r < 18'sd0) begin
      r = 18'sd0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/tld_step.sv @@
// Shared Bresenham step unit: moves both endpoints one pixel along the walk.
// Depends on tld_pkg for the step control struct.
`default_nettype none

module tld_step #(
  parameter int CW = 14,
  parameter int EW = 15,
  parameter int MW = 12
) (
  input  var tld_pkg::tld_step_ctl_t ctl,
  input  wire logic signed [CW-1:0]  x0,
  input  wire logic signed [CW-1:0]  y0,
  input  wire logic signed [CW-1:0]  x1,
  input  wire logic signed [CW-1:0]  y1,
  input  wire logic signed [EW-1:0]  err,
  input  wire logic [MW-1:0]         inc,
  input  wire logic [MW-1:0]         dec,
  output logic signed [CW-1:0]       x0_nxt,
  output logic signed [CW-1:0]       y0_nxt,
  output logic signed [CW-1:0]       x1_nxt,
  output logic signed [CW-1:0]       y1_nxt,
  output logic signed [EW-1:0]       err_nxt,
  output logic                       ov
);

  logic                 take;
  logic                 p_neg;
  logic                 s_neg;
  logic signed [CW-1:0] p_d;
  logic signed [CW-1:0] s_d;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic [EW-1:0]        inc2;
  logic [EW-1:0]        dec2;

  always_comb begin
    take  = !err[EW-1];
    p_neg = ctl.neg_p ^ ctl.retreat;
    s_neg = ctl.neg_s ^ ctl.retreat;
    p_d   = p_neg ? {CW{1'b1}} : CW'(1);
    if (take) begin
      s_d = s_neg ? {CW{1'b1}} : CW'(1);
    end else begin
      s_d = '0;
    end
    dx      = ctl.major_x ? p_d : s_d;
    dy      = ctl.major_x ? s_d : p_d;
    x0_nxt  = x0 + dx;
    x1_nxt  = x1 + dx;
    y0_nxt  = y0 + dy;
    y1_nxt  = y1 + dy;
    inc2    = EW'({inc, 1'b0});
    dec2    = take ? EW'({dec, 1'b0}) : '0;
    err_nxt = $signed(err + inc2 - dec2);
    ov      = take;
  end

endmodule

`default_nettype wire

@@ sv/thick_line_decomposer.sv @@
// Thick-line decomposer top level: clipping, octant setup, sequencer and output register.
// Depends on tld_pkg and tld_step.
`default_nettype none

// One command is accepted while the block is idle. It then passes through the clip, delta
// and setup states, takes one start-adjust step per cycle (0 to thickness-1 steps, set by
// side_mode and octant) and closes the adjust walk, then emits one component line per
// cycle as long as the output is not stalled (thickness lines, at least one), and returns
// to idle, where the next command is taken. All walk steps run through the single
// Bresenham step unit. in_stall is high while a command is in progress; the last line
// may still wait in the output register when the next command is taken.
module thick_line_decomposer #(
  parameter int MAX_THICKNESS = 64,
  parameter int COORD_BITS    = 12
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic                               cfg_index,
  input  wire logic [tld_pkg::CFG_W-1:0]          cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [15:0]                 in_start_x,
  input  wire logic signed [15:0]                 in_start_y,
  input  wire logic signed [15:0]                 in_end_x,
  input  wire logic signed [15:0]                 in_end_y,
  input  wire logic [6:0]                         in_thickness,
  input  wire logic [1:0]                         in_side_mode,
  input  wire logic [15:0]                        in_colour,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [tld_pkg::LINE_W-1:0]       out_line_x0,
  output logic signed [tld_pkg::LINE_W-1:0]       out_line_y0,
  output logic signed [tld_pkg::LINE_W-1:0]       out_line_x1,
  output logic signed [tld_pkg::LINE_W-1:0]       out_line_y1,
  output logic                                    out_overlap_major,
  output logic [15:0]                             out_line_colour,
  output logic                                    out_last_line
);

  localparam int CW    = COORD_BITS + 2;
  localparam int EW    = COORD_BITS + 3;
  localparam int MW    = COORD_BITS;
  localparam int TW    = $clog2(MAX_THICKNESS + 1);
  localparam int LIM_I = 1 << COORD_BITS;
  localparam logic signed [17:0] LIM18 = 18'(LIM_I);
  localparam logic [6:0] TMAX7 = 7'(MAX_THICKNESS);

  tld_pkg::tld_state_t state_r, state_nxt;

  logic [tld_pkg::CFG_W-1:0] width_r, height_r;
  logic signed [15:0] sx_r, sy_r, ex_r, ey_r;
  logic signed [15:0] sx_nxt, sy_nxt, ex_nxt, ey_nxt;
  logic [6:0]  t_raw_r, t_raw_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [15:0] colour_r, colour_nxt;

  logic signed [CW-1:0] x0_r, y0_r, x1_r, y1_r;
  logic signed [CW-1:0] x0_nxt, y0_nxt, x1_nxt, y1_nxt;
  logic [TW-1:0] t_r, t_nxt;
  logic [TW-1:0] cnt_r, cnt_nxt;
  logic [MW-1:0] adx_r, ady_r, adx_nxt, ady_nxt;
  logic          dxn_r, dyn_r, dxn_nxt, dyn_nxt;
  logic [MW-1:0] inc_r, dec_r, inc_nxt, dec_nxt;
  logic          major_x_r, neg_p_r, neg_s_r;
  logic          major_x_nxt, neg_p_nxt, neg_s_nxt;
  logic signed [EW-1:0] err_r, err_nxt, err_init_r, err_init_nxt;
  logic          ov_r, ov_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic signed [tld_pkg::LINE_W-1:0] ox0_r, oy0_r, ox1_r, oy1_r;
  logic signed [tld_pkg::LINE_W-1:0] ox0_nxt, oy0_nxt, ox1_nxt, oy1_nxt;
  logic          oov_r, oov_nxt, olast_r, olast_nxt;
  logic [15:0]   ocol_r, ocol_nxt;

  tld_pkg::tld_step_ctl_t step_ctl;
  logic signed [CW-1:0] sx0, sy0, sx1, sy1;
  logic signed [EW-1:0] serr;
  logic                 sov;

  logic signed [17:0] lim_w, lim_h;
  logic signed [CW-1:0] dx, dy;
  logic          swap, sa_neg, sb_neg, in_take, out_free;
  logic [TW-1:0] adj, tm1;
  logic [MW-1:0] inc_sel, dec_sel;

  assign step_ctl.major_x = major_x_r;
  assign step_ctl.neg_p   = neg_p_r;
  assign step_ctl.neg_s   = neg_s_r;
  assign step_ctl.retreat = (state_r == tld_pkg::ST_ADJ);

  tld_step #(.CW(CW), .EW(EW), .MW(MW)) u_step (
    .ctl     (step_ctl),
    .x0      (x0_r),
    .y0      (y0_r),
    .x1      (x1_r),
    .y1      (y1_r),
    .err     (err_r),
    .inc     (inc_r),
    .dec     (dec_r),
    .x0_nxt  (sx0),
    .y0_nxt  (sy0),
    .x1_nxt  (sx1),
    .y1_nxt  (sy1),
    .err_nxt (serr),
    .ov      (sov)
  );

  assign in_stall = (state_r != tld_pkg::ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    t_raw_nxt     = t_raw_r;
    mode_nxt      = mode_r;
    colour_nxt    = colour_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    t_nxt         = t_r;
    cnt_nxt       = cnt_r;
    adx_nxt       = adx_r;
    ady_nxt       = ady_r;
    dxn_nxt       = dxn_r;
    dyn_nxt       = dyn_r;
    inc_nxt       = inc_r;
    dec_nxt       = dec_r;
    major_x_nxt   = major_x_r;
    neg_p_nxt     = neg_p_r;
    neg_s_nxt     = neg_s_r;
    err_nxt       = err_r;
    err_init_nxt  = err_init_r;
    ov_nxt        = ov_r;
    out_valid_nxt = out_valid_r && out_stall;
    ox0_nxt       = ox0_r;
    oy0_nxt       = oy0_r;
    ox1_nxt       = ox1_r;
    oy1_nxt       = oy1_r;
    oov_nxt       = oov_r;
    olast_nxt     = olast_r;
    ocol_nxt      = ocol_r;

    lim_w   = ({5'd0, width_r} > LIM18) ? LIM18 : $signed({5'd0, width_r});
    lim_h   = ({5'd0, height_r} > LIM18) ? LIM18 : $signed({5'd0, height_r});
    dx      = x1_r - x0_r;
    dy      = y1_r - y0_r;
    tm1     = t_r - TW'(1);
    swap    = !(dxn_r ^ dyn_r);
    sa_neg  = dyn_r;
    sb_neg  = dxn_r;
    inc_sel = adx_r;
    dec_sel = ady_r;

    case (mode_r)
      tld_pkg::MODE_CCW: adj = tm1;
      tld_pkg::MODE_CW:  adj = '0;
      default:           adj = t_r >> 1;
    endcase

    if (ady_r >= adx_r) begin
      if (swap) begin
        adj    = tm1 - adj;
        sb_neg = !sb_neg;
      end else begin
        sa_neg = !sa_neg;
      end
    end else begin
      inc_sel = ady_r;
      dec_sel = adx_r;
      if (swap) begin
        sa_neg = !sa_neg;
      end else begin
        adj    = tm1 - adj;
        sb_neg = !sb_neg;
      end
    end

    case (state_r)
      tld_pkg::ST_IDLE: begin
        if (in_take) begin
          sx_nxt     = in_start_x;
          sy_nxt     = in_start_y;
          ex_nxt     = in_end_x;
          ey_nxt     = in_end_y;
          t_raw_nxt  = in_thickness;
          mode_nxt   = in_side_mode;
          colour_nxt = in_colour;
          state_nxt  = tld_pkg::ST_CLIP;
        end
      end
      tld_pkg::ST_CLIP: begin
        x0_nxt = CW'(tld_pkg::clip(sx_r, lim_w));
        y0_nxt = CW'(tld_pkg::clip(sy_r, lim_h));
        x1_nxt = CW'(tld_pkg::clip(ex_r, lim_w));
        y1_nxt = CW'(tld_pkg::clip(ey_r, lim_h));
        if (t_raw_r == 7'd0) begin
          t_nxt = TW'(1);
        end else if (t_raw_r > TMAX7) begin
          t_nxt = TW'(MAX_THICKNESS);
        end else begin
          t_nxt = TW'(t_raw_r);
        end
        state_nxt = tld_pkg::ST_DELTA;
      end
      tld_pkg::ST_DELTA: begin
        dxn_nxt   = dx[CW-1];
        dyn_nxt   = dy[CW-1];
        adx_nxt   = dx[CW-1] ? MW'(-dx) : MW'(dx);
        ady_nxt   = dy[CW-1] ? MW'(-dy) : MW'(dy);
        state_nxt = tld_pkg::ST_SETUP;
      end
      tld_pkg::ST_SETUP: begin
        major_x_nxt  = (ady_r >= adx_r);
        neg_p_nxt    = (ady_r >= adx_r) ? sa_neg : sb_neg;
        neg_s_nxt    = (ady_r >= adx_r) ? sb_neg : sa_neg;
        inc_nxt      = inc_sel;
        dec_nxt      = dec_sel;
        err_init_nxt = $signed(EW'({inc_sel, 1'b0}) - EW'(dec_sel));
        err_nxt      = $signed(EW'({inc_sel, 1'b0}) - EW'(dec_sel));
        cnt_nxt      = adj;
        state_nxt    = tld_pkg::ST_ADJ;
      end
      tld_pkg::ST_ADJ: begin
        if (cnt_r == '0) begin
          err_nxt   = err_init_r;
          cnt_nxt   = tm1;
          ov_nxt    = 1'b0;
          state_nxt = tld_pkg::ST_EMIT;
        end else begin
          x0_nxt  = sx0;
          y0_nxt  = sy0;
          x1_nxt  = sx1;
          y1_nxt  = sy1;
          err_nxt = serr;
          cnt_nxt = cnt_r - TW'(1);
        end
      end
      tld_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          ox0_nxt       = tld_pkg::LINE_W'(x0_r);
          oy0_nxt       = tld_pkg::LINE_W'(y0_r);
          ox1_nxt       = tld_pkg::LINE_W'(x1_r);
          oy1_nxt       = tld_pkg::LINE_W'(y1_r);
          oov_nxt       = ov_r;
          ocol_nxt      = colour_r;
          olast_nxt     = (cnt_r == '0);
          if (cnt_r == '0) begin
            state_nxt = tld_pkg::ST_IDLE;
          end else begin
            x0_nxt  = sx0;
            y0_nxt  = sy0;
            x1_nxt  = sx1;
            y1_nxt  = sy1;
            err_nxt = serr;
            ov_nxt  = sov;
            cnt_nxt = cnt_r - TW'(1);
          end
        end
      end
      default: begin
        state_nxt = tld_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tld_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= tld_pkg::WIDTH_RESET;
      height_r <= tld_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == tld_pkg::REG_SCREEN_WIDTH) begin
        width_r <= cfg_wdata;
      end else begin
        height_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    ex_r       <= ex_nxt;
    ey_r       <= ey_nxt;
    t_raw_r    <= t_raw_nxt;
    mode_r     <= mode_nxt;
    colour_r   <= colour_nxt;
    x0_r       <= x0_nxt;
    y0_r       <= y0_nxt;
    x1_r       <= x1_nxt;
    y1_r       <= y1_nxt;
    t_r        <= t_nxt;
    cnt_r      <= cnt_nxt;
    adx_r      <= adx_nxt;
    ady_r      <= ady_nxt;
    dxn_r      <= dxn_nxt;
    dyn_r      <= dyn_nxt;
    inc_r      <= inc_nxt;
    dec_r      <= dec_nxt;
    major_x_r  <= major_x_nxt;
    neg_p_r    <= neg_p_nxt;
    neg_s_r    <= neg_s_nxt;
    err_r      <= err_nxt;
    err_init_r <= err_init_nxt;
    ov_r       <= ov_nxt;
    ox0_r      <= ox0_nxt;
    oy0_r      <= oy0_nxt;
    ox1_r      <= ox1_nxt;
    oy1_r      <= oy1_nxt;
    oov_r      <= oov_nxt;
    olast_r    <= olast_nxt;
    ocol_r     <= ocol_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_line_x0       = ox0_r;
  assign out_line_y0       = oy0_r;
  assign out_line_x1       = ox1_r;
  assign out_line_y1       = oy1_r;
  assign out_overlap_major = oov_r;
  assign out_line_colour   = ocol_r;
  assign out_last_line     = olast_r;

endmodule

`default_nettype wire

@@ sv/tld_checker.sv @@
// Port-level checks for the thick-line decomposer and the bind that attaches them.
// Depends on tld_pkg and on the thick_line_decomposer top level.
`default_nettype none

module tld_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_stall,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic signed [tld_pkg::LINE_W-1:0]  out_line_x0,
  input wire logic signed [tld_pkg::LINE_W-1:0]  out_line_y0,
  input wire logic                               out_overlap_major,
  input wire logic                               out_last_line
);

  // No result is offered in the cycle after reset.
  a_reset_quiet : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A command in progress blocks the input.
  a_busy_after_take : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a command transfer");

  // The next component line is offered right after a line that is not the last one.
  a_more_lines : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_line |=> out_valid)
    else $error("no component line after a line that was not the last");

  // A stalled result holds.
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_line_x0) &&
    $stable(out_line_y0) && $stable(out_overlap_major) && $stable(out_last_line))
    else $error("stalled result changed");

endmodule

bind thick_line_decomposer tld_checker u_tld_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_line_x0       (out_line_x0),
  .out_line_y0       (out_line_y0),
  .out_overlap_major (out_overlap_major),
  .out_last_line     (out_last_line)
);

`default_nettype wire

@@ bench/thick_line_decomposer_tb.sv @@
// Self-checking bench for thick_line_decomposer: drives line commands, predicts every
// component line, and compares each transfer on the result side, under random idling.
// Depends on tld_pkg and the block's RTL.
module thick_line_decomposer_tb;

  localparam int MAX_THICK     = 64;
  localparam int COORD_SPAN    = 4096;
  localparam int SETTLE_CYCLES = 150;
  localparam int IDLE_LIMIT    = 3000;

  localparam logic [1:0] MODE_RESERVED = 2'd3;

  typedef struct {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic [6:0]         thick;
    logic [1:0]         mode;
    logic [15:0]        colour;
  } line_cmd_t;

  typedef struct {
    logic signed [13:0] x0;
    logic signed [13:0] y0;
    logic signed [13:0] x1;
    logic signed [13:0] y1;
    logic               ovl;
    logic [15:0]        colour;
    logic               last;
  } seg_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         cfg_we = 1'b0;
  logic                         cfg_index = tld_pkg::REG_SCREEN_WIDTH;
  logic [tld_pkg::CFG_W-1:0]    cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [15:0]           in_start_x = '0;
  logic signed [15:0]           in_start_y = '0;
  logic signed [15:0]           in_end_x = '0;
  logic signed [15:0]           in_end_y = '0;
  logic [6:0]                   in_thickness = '0;
  logic [1:0]                   in_side_mode = tld_pkg::MODE_CENTER;
  logic [15:0]                  in_colour = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [tld_pkg::LINE_W-1:0] out_line_x0;
  logic signed [tld_pkg::LINE_W-1:0] out_line_y0;
  logic signed [tld_pkg::LINE_W-1:0] out_line_x1;
  logic signed [tld_pkg::LINE_W-1:0] out_line_y1;
  logic                         out_overlap_major;
  logic [15:0]                  out_line_colour;
  logic                         out_last_line;

  thick_line_decomposer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_start_x        (in_start_x),
    .in_start_y        (in_start_y),
    .in_end_x          (in_end_x),
    .in_end_y          (in_end_y),
    .in_thickness      (in_thickness),
    .in_side_mode      (in_side_mode),
    .in_colour         (in_colour),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_line_x0       (out_line_x0),
    .out_line_y0       (out_line_y0),
    .out_line_x1       (out_line_x1),
    .out_line_y1       (out_line_y1),
    .out_overlap_major (out_overlap_major),
    .out_line_colour   (out_line_colour),
    .out_last_line     (out_last_line)
  );

  always #5 clk = ~clk;

  line_cmd_t pending_cmds[$];
  seg_t      expected_segs[$];
  line_cmd_t held_cmd;
  seg_t      want_seg;

  logic [12:0] scr_w = tld_pkg::WIDTH_RESET;
  logic [12:0] scr_h = tld_pkg::HEIGHT_RESET;

  int  mismatches = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  gap_pct = 0;
  int  stall_pct = 0;
  bit  quiet = 1'b0;
  int  idle_cycles = 0;

  function automatic int span(logic [12:0] r);
    return (r > 13'(COORD_SPAN)) ? COORD_SPAN : int'(r);
  endfunction

  function automatic int clamp_coord(logic signed [15:0] v, int lim);
    int r;
    r = v;
    if (r >= lim) r = lim - 1;
    if (r < 0) r = 0;
    return r;
  endfunction

  function automatic void add_seg(int x0, int y0, int x1, int y1, bit ov,
                                  logic [15:0] colour, bit last);
    seg_t s;
    s.x0 = 14'(x0);
    s.y0 = 14'(y0);
    s.x1 = 14'(x1);
    s.y1 = 14'(y1);
    s.ovl = ov;
    s.colour = colour;
    s.last = last;
    expected_segs.push_back(s);
  endfunction

  // Clip, fold into an octant, shift the start line sideways, then step out the
  // parallel lines with a perpendicular Bresenham walk.
  function automatic void decompose_cmd(line_cmd_t c);
    int w, h, x0, y0, x1, y1, t, da, db, sa, sb, adj, err, i;
    bit flip, ov;
    w = span(scr_w);
    h = span(scr_h);
    x0 = clamp_coord(c.sx, w);
    y0 = clamp_coord(c.sy, h);
    x1 = clamp_coord(c.ex, w);
    y1 = clamp_coord(c.ey, h);
    t = c.thick;
    if (t < 1) t = 1;
    if (t > MAX_THICK) t = MAX_THICK;
    db = x1 - x0;
    da = y1 - y0;
    sa = 1;
    sb = 1;
    flip = 1'b1;
    if (da < 0) begin
      da = -da;
      sa = -1;
      flip = !flip;
    end
    if (db < 0) begin
      db = -db;
      sb = -1;
      flip = !flip;
    end
    adj = t / 2;
    if (c.mode == tld_pkg::MODE_CCW) adj = t - 1;
    else if (c.mode == tld_pkg::MODE_CW) adj = 0;
    if (da >= db) begin
      if (flip) begin
        adj = (t - 1) - adj;
        sb = -sb;
      end else begin
        sa = -sa;
      end
      err = 2 * db - da;
      for (i = adj; i > 0; i--) begin
        x0 -= sa;
        x1 -= sa;
        if (err >= 0) begin
          y0 -= sb;
          y1 -= sb;
          err -= 2 * da;
        end
        err += 2 * db;
      end
      add_seg(x0, y0, x1, y1, 1'b0, c.colour, t == 1);
      err = 2 * db - da;
      for (i = t; i > 1; i--) begin
        ov = 1'b0;
        x0 += sa;
        x1 += sa;
        if (err >= 0) begin
          y0 += sb;
          y1 += sb;
          err -= 2 * da;
          ov = 1'b1;
        end
        err += 2 * db;
        add_seg(x0, y0, x1, y1, ov, c.colour, i == 2);
      end
    end else begin
      if (flip) begin
        sa = -sa;
      end else begin
        adj = (t - 1) - adj;
        sb = -sb;
      end
      err = 2 * da - db;
      for (i = adj; i > 0; i--) begin
        y0 -= sb;
        y1 -= sb;
        if (err >= 0) begin
          x0 -= sa;
          x1 -= sa;
          err -= 2 * db;
        end
        err += 2 * da;
      end
      add_seg(x0, y0, x1, y1, 1'b0, c.colour, t == 1);
      err = 2 * da - db;
      for (i = t; i > 1; i--) begin
        ov = 1'b0;
        y0 += sb;
        y1 += sb;
        if (err >= 0) begin
          x0 += sa;
          x1 += sa;
          err -= 2 * db;
          ov = 1'b1;
        end
        err += 2 * da;
        add_seg(x0, y0, x1, y1, ov, c.colour, i == 2);
      end
    end
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Command driver: holds a stalled transfer, otherwise idles or takes the next command.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        decompose_cmd(held_cmd);
        if (!quiet && $urandom_range(0, 99) < gap_pct) gap_left = $urandom_range(1, 17);
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          held_cmd = pending_cmds.pop_front();
          in_start_x   <= held_cmd.sx;
          in_start_y   <= held_cmd.sy;
          in_end_x     <= held_cmd.ex;
          in_end_y     <= held_cmd.ey;
          in_thickness <= held_cmd.thick;
          in_side_mode <= held_cmd.mode;
          in_colour    <= held_cmd.colour;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and downstream stall generator.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_segs.size() == 0) begin
          flag_mismatch("line with no command pending (x0)", out_line_x0, 0);
        end else begin
          want_seg = expected_segs.pop_front();
          if (out_line_x0 !== want_seg.x0) flag_mismatch("line_x0", out_line_x0, want_seg.x0);
          if (out_line_y0 !== want_seg.y0) flag_mismatch("line_y0", out_line_y0, want_seg.y0);
          if (out_line_x1 !== want_seg.x1) flag_mismatch("line_x1", out_line_x1, want_seg.x1);
          if (out_line_y1 !== want_seg.y1) flag_mismatch("line_y1", out_line_y1, want_seg.y1);
          if (out_overlap_major !== want_seg.ovl)
            flag_mismatch("overlap_major", out_overlap_major, want_seg.ovl);
          if (out_line_colour !== want_seg.colour)
            flag_mismatch("line_colour", out_line_colour, want_seg.colour);
          if (out_last_line !== want_seg.last)
            flag_mismatch("last_line", out_last_line, want_seg.last);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 16);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic logic signed [15:0] rand_coord(int lim);
    int sel;
    sel = $urandom_range(0, 99);
    if (lim < 1) lim = 1;
    if (sel < 70) return 16'(int'($urandom_range(0, lim + 39)) - 20);
    if (sel < 85) return 16'($urandom);
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return -16'sd1;
      3: return 16'sd0;
      4: return 16'(lim - 1);
      default: return 16'(lim);
    endcase
  endfunction

  function automatic line_cmd_t rand_cmd();
    line_cmd_t c;
    int sel;
    c.sx = rand_coord(span(scr_w));
    c.sy = rand_coord(span(scr_h));
    c.ex = rand_coord(span(scr_w));
    c.ey = rand_coord(span(scr_h));
    sel = $urandom_range(0, 99);
    if (sel < 50) c.thick = 7'($urandom_range(0, 8));
    else if (sel < 85) c.thick = 7'($urandom_range(0, MAX_THICK));
    else c.thick = 7'($urandom_range(MAX_THICK + 1, 127));
    c.mode = 2'($urandom_range(0, 3));
    c.colour = 16'($urandom);
    return c;
  endfunction

  task automatic add_cmd(int sx, int sy, int ex, int ey, int thick, logic [1:0] mode,
                         logic [15:0] colour);
    line_cmd_t c;
    c.sx = 16'(sx);
    c.sy = 16'(sy);
    c.ex = 16'(ex);
    c.ey = 16'(ey);
    c.thick = 7'(thick);
    c.mode = mode;
    c.colour = colour;
    pending_cmds.push_back(c);
  endtask

  task automatic settle();
    while (pending_cmds.size() != 0 || in_valid || expected_segs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_screen(logic [12:0] w, logic [12:0] h);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= tld_pkg::REG_SCREEN_WIDTH;
    cfg_wdata <= w;
    scr_w = w;
    @(posedge clk);
    cfg_index <= tld_pkg::REG_SCREEN_HEIGHT;
    cfg_wdata <= h;
    scr_h = h;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int count, int gaps, int stalls);
    gap_pct = gaps;
    stall_pct = stalls;
    repeat (count) pending_cmds.push_back(rand_cmd());
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    gap_pct = 30;
    stall_pct = 30;
    add_cmd(10, 10, 10, 10, 0, tld_pkg::MODE_CENTER, 16'h1234);
    add_cmd(0, 100, 319, 100, 5, tld_pkg::MODE_CENTER, 16'hFFFF);
    add_cmd(50, 0, 50, 239, 4, tld_pkg::MODE_CW, 16'h0000);
    add_cmd(0, 0, 200, 200, 7, tld_pkg::MODE_CCW, 16'hA5A5);
    add_cmd(160, 120, 200, 20, 6, tld_pkg::MODE_CENTER, 16'h0F0F);
    add_cmd(160, 120, 100, 230, 6, tld_pkg::MODE_CW, 16'hF0F0);
    add_cmd(160, 120, 20, 110, 6, tld_pkg::MODE_CCW, 16'h5A5A);
    add_cmd(160, 120, 300, 150, 3, MODE_RESERVED, 16'h00FF);
    add_cmd(160, 120, 150, 0, 8, tld_pkg::MODE_CENTER, 16'hFF00);
    add_cmd(-32768, -32768, 32767, 32767, 1, tld_pkg::MODE_CENTER, 16'h8001);
    add_cmd(32767, -32768, -32768, 32767, 2, tld_pkg::MODE_CW, 16'h7FFE);
    add_cmd(10, 10, 300, 60, 64, tld_pkg::MODE_CCW, 16'h3C3C);
    add_cmd(300, 200, 20, 30, 65, tld_pkg::MODE_CENTER, 16'hC3C3);
    add_cmd(5, 230, 310, 5, 127, tld_pkg::MODE_CW, 16'h6666);
    add_cmd(319, 0, 0, 239, 63, MODE_RESERVED, 16'h9999);
    add_cmd(100, 50, 250, 180, 1, tld_pkg::MODE_CCW, 16'h1111);
    add_cmd(250, 180, 100, 50, 2, tld_pkg::MODE_CENTER, 16'hEEEE);
    add_cmd(319, 239, 319, 239, 64, tld_pkg::MODE_CENTER, 16'h2468);
    run_random(22, 30, 30);

    set_screen(13'd0, 13'd8191);
    run_random(15, 40, 20);
    set_screen(13'd8191, 13'd0);
    run_random(15, 20, 40);
    set_screen(13'd1, 13'd1);
    run_random(10, 30, 30);
    set_screen(13'd4096, 13'd4096);
    run_random(25, 10, 10);
    set_screen(13'd100, 13'd37);
    run_random(25, 60, 60);

    set_screen(tld_pkg::WIDTH_RESET, tld_pkg::HEIGHT_RESET);
    quiet = 1'b1;
    run_random(30, 0, 0);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
